FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/core/smd_pkg.sv
// ---------------------------------------------------------------------------
// Scaled multiply-divide package
// Widths, defaults and sequencer state codes.
// ---------------------------------------------------------------------------
package smd_pkg;

  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned MultWidth   = 32;
  localparam int unsigned QuoPartWidth = 32;
  localparam int unsigned RemPartWidth = 31;
  localparam int unsigned DivWidth    = 31;
  localparam int unsigned ResultWidth = 32;

  localparam int unsigned InFieldBits = MultWidth + QuoPartWidth + RemPartWidth + DivWidth;
  localparam int unsigned InDataWidth = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((ResultWidth + 7) / 8) * 8;

  localparam int unsigned QuoPartLsb = MultWidth;
  localparam int unsigned RemPartLsb = QuoPartLsb + QuoPartWidth;
  localparam int unsigned DivLsb     = RemPartLsb + RemPartWidth;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_ROUND  = 4'b0100,
    ST_FINISH = 4'b1000
  } smd_state_e;

endpackage

FILE: rtl/core/scaled_multiply_divide_unit.sv
// ---------------------------------------------------------------------------
// Scaled multiply-divide unit
// round(a * m / d) by shift-and-add, m given as m / d and m % d.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) takes one item: multiplicand, quotient part,
//   remainder part and divisor packed in tdata. Master channel (m_axis_*)
//   returns the rounded signed 32-bit result.
//   An accumulate step and a doubling step, each add/compare/subtract, walk
//   the multiplicand magnitude, one bit per cycle, from the low bit up to
//   its highest set bit (k bits, k = 0..DATA_WIDTH). Then the ROUND state
//   rounds and the FINISH state applies the sign into the output register.
//   The slave side is ready only while the sequencer is idle, so a new item
//   is accepted only after the last one has left the final step.
//   The output register holds a finished item while the receiver stalls; the
//   next item is accepted and computed meanwhile and waits in the final step
//   until the register frees up.
//   Reset clears the sequencer and the output valid flag; no other state is
//   kept between items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_multiply_divide_unit #(
  parameter int unsigned DATA_WIDTH = smd_pkg::DataWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // multiplicand[31:0], quotient_part[63:32], remainder_part[94:64],
  // divisor_value[125:95], zero pad[127:126]
  input  logic [smd_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // scaled_result[31:0]
  output logic [smd_pkg::OutDataWidth-1:0] m_axis_tdata_o
);

  import smd_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;

  smd_state_e state_q, state_d;

  logic [DW-1:0] mag_q, mag_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] qn_q, qn_d;
  logic [DW-1:0] rn_q, rn_d;
  logic [DW-1:0] div_q, div_d;
  logic          neg_q, neg_d;
  logic [ResultWidth-1:0] out_data_q, out_data_d;
  logic          out_valid_q, out_valid_d;

  logic          in_accept;
  logic [DW-1:0] in_mult;
  logic [DW-1:0] in_mag;
  logic [DW-1:0] rem_sum;
  logic          acc_ge;
  logic [DW-1:0] quo_sum;
  logic [DW-1:0] rn_dbl;
  logic          dbl_ge;
  logic [DW-1:0] mag_shr;
  logic          round_up;
  logic [DW-1:0] res_w;
  logic          out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataWidth'(out_data_q);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign in_mult = DW'($signed(s_axis_tdata_i[MultWidth-1:0]));
  assign in_mag  = in_mult[DW-1] ? (~in_mult + DW'(1)) : in_mult;

  // accumulate step
  assign rem_sum = rem_q + rn_q;
  assign acc_ge  = (rem_sum >= div_q);
  assign quo_sum = quo_q + qn_q + DW'(acc_ge);

  // doubling step
  assign rn_dbl  = {rn_q[DW-2:0], 1'b0};
  assign dbl_ge  = (rn_dbl >= div_q);
  assign mag_shr = mag_q >> 1;

  assign round_up = (rem_q > (div_q >> 1));
  assign res_w    = neg_q ? (~quo_q + DW'(1)) : quo_q;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    qn_d        = qn_q;
    rn_d        = rn_q;
    div_d       = div_q;
    neg_d       = neg_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mag_d = in_mag;
          neg_d = in_mult[DW-1];
          quo_d = '0;
          rem_d = '0;
          qn_d  = DW'(s_axis_tdata_i[QuoPartLsb +: QuoPartWidth]);
          rn_d  = DW'(s_axis_tdata_i[RemPartLsb +: RemPartWidth]);
          div_d = DW'(s_axis_tdata_i[DivLsb +: DivWidth]);
          state_d = (in_mag == '0) ? ST_ROUND : ST_RUN;
        end
      end
      ST_RUN: begin
        if (mag_q[0]) begin
          quo_d = quo_sum;
          rem_d = acc_ge ? (rem_sum - div_q) : rem_sum;
        end
        qn_d  = {qn_q[DW-2:0], 1'b0} + DW'(dbl_ge);
        rn_d  = dbl_ge ? (rn_dbl - div_q) : rn_dbl;
        mag_d = mag_shr;
        if (mag_shr == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        quo_d   = quo_q + DW'(round_up);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data_d  = ResultWidth'($signed(res_w));
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    qn_q       <= qn_d;
    rn_q       <= rn_d;
    div_q      <= div_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  `ASSERT_NEVER(a_run_mag_zero, (state_q == ST_RUN) && (mag_q == '0), "run with empty magnitude")
  `ASSERT_CLK(a_accept_run, in_accept && (in_mag != '0) |=> (state_q == ST_RUN), "accept did not start run")
  `ASSERT_CLK(a_valid_from_finish, $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH), "result not from final step")
  `ASSERT_CLK(a_stall_holds, out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q), "stalled result lost")

endmodule
